// ===== design/mwre_pkg.sv =====
// ----------------------------------------------------------------------------
// mwre_pkg: shared definitions of the masked weighted row extraction
// Widths of the fixed fields, parameter defaults, register indexes,
// status codes and the queue status word.
// ----------------------------------------------------------------------------
package mwre_pkg;

  // Parameter defaults.
  localparam int unsigned WEIGHT_FRAC_BITS_DEF = 16;
  localparam int unsigned SAMPLE_BITS_DEF      = 32;

  // Fixed field widths.
  localparam int unsigned WORD_W     = 32;
  localparam int unsigned WEIGHT_W   = 19;
  // The square of a weight is never negative and needs one bit less than
  // the full signed product.
  localparam int unsigned WSQ_FULL_W = 2 * WEIGHT_W;
  localparam int unsigned WSQ_W      = WSQ_FULL_W - 1;
  localparam int unsigned FLUX_W     = 64;
  localparam int unsigned VAR_W      = 63;
  localparam int unsigned NORM_W     = 48;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned CFG_IDX_W  = 2;

  // Depth of the queue between the front and back ends.
  localparam int unsigned QUEUE_DEPTH = 4;

  // Reset values of the configuration registers.
  localparam logic [WORD_W-1:0] BAD_MASK_RST     = '0;
  localparam logic [WORD_W-1:0] REQUIRE_MASK_RST = 32'd1;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BAD_MASK     = 2'd0,
    CFG_REQUIRE_MASK = 2'd1
  } cfg_reg_e;

  // Row status codes.
  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK        = 2'd0,
    STATUS_SATURATED = 2'd1,
    STATUS_BAD_TRACE = 2'd2
  } status_e;

  // Fill state of the queue, seen by both ends.
  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

// ===== design/mwre_front.sv =====
// ----------------------------------------------------------------------------
// mwre_front: pixel intake and classification
// Holds the mask registers, decides whether a pixel is used and pushes the
// trimmed pixel word into the queue.
// ----------------------------------------------------------------------------
module mwre_front #(
  parameter int unsigned SAMPLE_BITS = mwre_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // Configuration write channel
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic [mwre_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [mwre_pkg::WORD_W-1:0]            cfg_data_i,
  // Pixel channel
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic signed [mwre_pkg::WORD_W-1:0]     pixel_value_i,
  input  logic [mwre_pkg::WORD_W-1:0]            pixel_variance_i,
  input  logic [mwre_pkg::WORD_W-1:0]            pixel_mask_i,
  input  logic signed [mwre_pkg::WEIGHT_W-1:0]   profile_weight_i,
  input  logic [mwre_pkg::WORD_W-1:0]            trace_mask_i,
  input  logic                                   row_end_i,
  // Queue write side
  output logic                                   push_o,
  output logic [2*SAMPLE_BITS+mwre_pkg::WEIGHT_W+1:0] item_o,
  input  mwre_pkg::queue_status_t                q_status_i
);

  logic [mwre_pkg::WORD_W-1:0] bad_mask_q;
  logic [mwre_pkg::WORD_W-1:0] require_mask_q;
  logic                        use_pixel;

  // The register file is always ready to take a word.
  assign cfg_ready_o = 1'b1;

  // Mask registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bad_mask_q     <= mwre_pkg::BAD_MASK_RST;
      require_mask_q <= mwre_pkg::REQUIRE_MASK_RST;
    end else if (cfg_valid_i) begin
      unique case (mwre_pkg::cfg_reg_e'(cfg_index_i))
        mwre_pkg::CFG_BAD_MASK:     bad_mask_q     <= cfg_data_i;
        mwre_pkg::CFG_REQUIRE_MASK: require_mask_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // A pixel counts when its trace has a required bit and its image mask
  // carries no bad bit.
  assign use_pixel = (|(trace_mask_i & require_mask_q)) && !(|(pixel_mask_i & bad_mask_q));

  // Words enter the queue whenever it has room.
  assign in_stall_o = q_status_i.full;
  assign push_o     = in_valid_i && !q_status_i.full;
  assign item_o     = {row_end_i, use_pixel, profile_weight_i,
                       pixel_variance_i[SAMPLE_BITS-1:0], pixel_value_i[SAMPLE_BITS-1:0]};

endmodule

// ===== design/mwre_queue.sv =====
// ----------------------------------------------------------------------------
// mwre_queue: short first-in first-out queue
// Decouples pixel intake from the arithmetic so that each side can stall
// without holding the other while the queue has room.
// ----------------------------------------------------------------------------
module mwre_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = mwre_pkg::QUEUE_DEPTH
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push_i,
  input  logic [WIDTH-1:0]        push_data_i,
  input  logic                    pop_i,
  output logic [WIDTH-1:0]        pop_data_o,
  output mwre_pkg::queue_status_t status_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push, do_pop;

  assign status_o.full  = (count_q == CNT_W'(DEPTH));
  assign status_o.empty = (count_q == '0);
  assign do_push        = push_i && !status_o.full;
  assign do_pop         = pop_i && !status_o.empty;
  assign pop_data_o     = slot_q[rd_ptr_q];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Slot storage needs no reset: the fill count guards every read.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== design/mwre_back.sv =====
// ----------------------------------------------------------------------------
// mwre_back: weighted accumulation pipeline
// Multiplies, accumulates with saturation and delivers one result word at
// the end of each row. The whole pipeline advances together and freezes
// while a finished result waits.
// ----------------------------------------------------------------------------
module mwre_back #(
  parameter int unsigned WEIGHT_FRAC_BITS = mwre_pkg::WEIGHT_FRAC_BITS_DEF,
  parameter int unsigned SAMPLE_BITS      = mwre_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // Queue read side
  output logic                                 pop_o,
  input  logic [2*SAMPLE_BITS+mwre_pkg::WEIGHT_W+1:0] item_i,
  input  mwre_pkg::queue_status_t              q_status_i,
  // Result channel
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [mwre_pkg::FLUX_W-1:0]   row_flux_o,
  output logic [mwre_pkg::VAR_W-1:0]           row_variance_o,
  output logic signed [mwre_pkg::NORM_W-1:0]   row_norm_o,
  output logic [mwre_pkg::STATUS_W-1:0]        row_status_o
);

  localparam int unsigned W_W    = mwre_pkg::WEIGHT_W;
  localparam int unsigned FLUX_W = mwre_pkg::FLUX_W;
  localparam int unsigned VAR_W  = mwre_pkg::VAR_W;
  localparam int unsigned NORM_W = mwre_pkg::NORM_W;
  localparam int unsigned VW_W   = SAMPLE_BITS + W_W;
  localparam int unsigned HI_W   = mwre_pkg::WSQ_W - WEIGHT_FRAC_BITS;
  localparam int unsigned MH_W   = SAMPLE_BITS + HI_W;
  localparam int unsigned ML_W   = SAMPLE_BITS + WEIGHT_FRAC_BITS;
  // Bit positions inside a queue word.
  localparam int unsigned VAR_LSB  = SAMPLE_BITS;
  localparam int unsigned W_LSB    = 2 * SAMPLE_BITS;
  localparam int unsigned USE_BIT  = W_LSB + W_W;
  localparam int unsigned LAST_BIT = USE_BIT + 1;

  localparam logic signed [FLUX_W-1:0] FLUX_MAX = {1'b0, {(FLUX_W-1){1'b1}}};
  localparam logic signed [FLUX_W-1:0] FLUX_MIN = {1'b1, {(FLUX_W-1){1'b0}}};
  localparam logic [VAR_W-1:0]         VAR_MAX  = '1;
  localparam logic signed [NORM_W-1:0] NORM_MAX = {1'b0, {(NORM_W-1){1'b1}}};
  localparam logic signed [NORM_W-1:0] NORM_MIN = {1'b1, {(NORM_W-1){1'b0}}};

  logic advance;

  // Unpacked queue word.
  logic signed [SAMPLE_BITS-1:0]          value_s;
  logic [SAMPLE_BITS-1:0]                 var_u;
  logic signed [W_W-1:0]                  weight_s;
  logic signed [VW_W-1:0]                 vw_prod;
  logic signed [mwre_pkg::WSQ_FULL_W-1:0] wsq_prod;

  // Stage 1: value times weight and weight squared.
  logic                                   v1_q, last1_q, use1_q;
  logic signed [VW_W-1:0]                 vw1_q;
  logic [mwre_pkg::WSQ_W-1:0]             wsq1_q;
  logic [SAMPLE_BITS-1:0]                 var1_q;
  logic signed [W_W-1:0]                  w1_q;

  // Stage 2: variance times the two halves of the squared weight.
  logic [HI_W-1:0]                        wsq_hi;
  logic [WEIGHT_FRAC_BITS-1:0]            wsq_lo;
  logic                                   v2_q, last2_q, use2_q;
  logic signed [VW_W-1:0]                 vw2_q;
  logic [MH_W-1:0]                        mh2_q;
  logic [ML_W-1:0]                        ml2_q;
  logic signed [W_W-1:0]                  w2_q;

  // Stage 3: variance term assembled.
  logic                                   v3_q, last3_q, use3_q;
  logic signed [VW_W-1:0]                 vw3_q;
  logic [VAR_W-1:0]                       term3_q;
  logic signed [W_W-1:0]                  w3_q;

  // Stage 4: row sums and flags.
  logic signed [FLUX_W-1:0]               flux_q, flux_d, flux_new;
  logic [VAR_W-1:0]                       var_q, var_d, var_new;
  logic signed [NORM_W-1:0]               norm_q, norm_d, norm_new;
  logic                                   fsat_q, fsat_d, fsat_new;
  logic                                   vsat_q, vsat_d, vsat_new;
  logic                                   wsat_q, wsat_d, wsat_new;
  logic signed [FLUX_W:0]                 flux_add;
  logic [VAR_W:0]                         var_add;
  logic signed [NORM_W:0]                 norm_add;
  mwre_pkg::status_e                      status_new;
  logic                                   emit;

  // Result register.
  logic                                   out_valid_q, out_valid_d;
  logic signed [FLUX_W-1:0]               row_flux_q;
  logic [VAR_W-1:0]                       row_var_q;
  logic signed [NORM_W-1:0]               row_norm_q;
  mwre_pkg::status_e                      row_status_q;

  // The pipeline moves unless a result is held by a stalled receiver.
  assign advance = !out_valid_q || !out_stall_i;
  assign pop_o   = advance && !q_status_i.empty;

  assign value_s  = $signed(item_i[SAMPLE_BITS-1:0]);
  assign var_u    = item_i[VAR_LSB +: SAMPLE_BITS];
  assign weight_s = $signed(item_i[W_LSB +: W_W]);
  assign vw_prod  = VW_W'(value_s) * VW_W'(weight_s);
  assign wsq_prod = mwre_pkg::WSQ_FULL_W'(weight_s) * mwre_pkg::WSQ_FULL_W'(weight_s);

  assign wsq_hi = wsq1_q[mwre_pkg::WSQ_W-1:WEIGHT_FRAC_BITS];
  assign wsq_lo = wsq1_q[WEIGHT_FRAC_BITS-1:0];

  // Stage valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (advance) begin
      v1_q <= !q_status_i.empty;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // Stage payloads.
  always_ff @(posedge clk_i) begin
    if (advance) begin
      last1_q <= item_i[LAST_BIT];
      use1_q  <= item_i[USE_BIT];
      vw1_q   <= vw_prod;
      wsq1_q  <= wsq_prod[mwre_pkg::WSQ_W-1:0];
      var1_q  <= var_u;
      w1_q    <= weight_s;

      last2_q <= last1_q;
      use2_q  <= use1_q;
      vw2_q   <= vw1_q;
      mh2_q   <= MH_W'(var1_q) * MH_W'(wsq_hi);
      ml2_q   <= ML_W'(var1_q) * ML_W'(wsq_lo);
      w2_q    <= w1_q;

      last3_q <= last2_q;
      use3_q  <= use2_q;
      vw3_q   <= vw2_q;
      term3_q <= VAR_W'(mh2_q) + VAR_W'(ml2_q[ML_W-1:WEIGHT_FRAC_BITS]);
      w3_q    <= w2_q;
    end
  end

  // Wide sums with one guard bit for the overflow test.
  assign flux_add = (FLUX_W+1)'(flux_q) + (FLUX_W+1)'(vw3_q);
  assign var_add  = {1'b0, var_q} + {1'b0, term3_q};
  assign norm_add = (NORM_W+1)'(norm_q) + (NORM_W+1)'(w3_q);

  // Saturating accumulation; a saturated sum holds for the rest of the row.
  always_comb begin
    flux_new = flux_q;
    var_new  = var_q;
    norm_new = norm_q;
    fsat_new = fsat_q;
    vsat_new = vsat_q;
    wsat_new = wsat_q;
    if (use3_q) begin
      if (!fsat_q) begin
        unique case (flux_add[FLUX_W:FLUX_W-1])
          2'b01: begin
            flux_new = FLUX_MAX;
            fsat_new = 1'b1;
          end
          2'b10: begin
            flux_new = FLUX_MIN;
            fsat_new = 1'b1;
          end
          default: flux_new = flux_add[FLUX_W-1:0];
        endcase
      end
      if (!vsat_q) begin
        if (var_add[VAR_W]) begin
          var_new  = VAR_MAX;
          vsat_new = 1'b1;
        end else begin
          var_new = var_add[VAR_W-1:0];
        end
      end
      if (!wsat_q) begin
        unique case (norm_add[NORM_W:NORM_W-1])
          2'b01: begin
            norm_new = NORM_MAX;
            wsat_new = 1'b1;
          end
          2'b10: begin
            norm_new = NORM_MIN;
            wsat_new = 1'b1;
          end
          default: norm_new = norm_add[NORM_W-1:0];
        endcase
      end
    end
  end

  // Row status; a bad trace wins over a saturated sum.
  always_comb begin
    if (norm_new == '0 || wsat_new) begin
      status_new = mwre_pkg::STATUS_BAD_TRACE;
    end else if (fsat_new || vsat_new) begin
      status_new = mwre_pkg::STATUS_SATURATED;
    end else begin
      status_new = mwre_pkg::STATUS_OK;
    end
  end

  // The last pixel of a row hands the sums over and clears them.
  assign emit = advance && v3_q && last3_q;

  always_comb begin
    if (last3_q) begin
      flux_d = '0;
      var_d  = '0;
      norm_d = '0;
      fsat_d = 1'b0;
      vsat_d = 1'b0;
      wsat_d = 1'b0;
    end else begin
      flux_d = flux_new;
      var_d  = var_new;
      norm_d = norm_new;
      fsat_d = fsat_new;
      vsat_d = vsat_new;
      wsat_d = wsat_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flux_q <= '0;
      var_q  <= '0;
      norm_q <= '0;
      fsat_q <= 1'b0;
      vsat_q <= 1'b0;
      wsat_q <= 1'b0;
    end else if (advance && v3_q) begin
      flux_q <= flux_d;
      var_q  <= var_d;
      norm_q <= norm_d;
      fsat_q <= fsat_d;
      vsat_q <= vsat_d;
      wsat_q <= wsat_d;
    end
  end

  // Result word register.
  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = v3_q && last3_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      row_flux_q   <= flux_new;
      row_var_q    <= var_new;
      row_norm_q   <= norm_new;
      row_status_q <= status_new;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign row_flux_o     = row_flux_q;
  assign row_variance_o = row_var_q;
  assign row_norm_o     = row_norm_q;
  assign row_status_o   = row_status_q;

endmodule

// ===== design/masked_weighted_row_extraction.sv =====
// ----------------------------------------------------------------------------
// masked_weighted_row_extraction: profile-weighted extraction of image rows
// Channel     | Direction | Handshake           | Word
// ------------|-----------|---------------------|------------------------------
// pixel       | in        | in_valid / stall    | value, variance, masks, weight
// row result  | out       | out_valid / stall   | flux, variance, norm, status
// config      | in        | cfg_valid / ready   | register index, data
//
// One pixel word is taken per cycle unless the pixel channel stalls; the back
// end keeps that rate since only its stage-4 accumulators carry state from
// word to word. A row result reaches the output register once its last pixel
// has passed through the queue and stages 1 to 3.
// Reset clears the sums, flags and queue and loads the mask registers.
// A held result freezes the back end; the four-word queue then fills and
// the pixel channel stalls.
// ----------------------------------------------------------------------------
module masked_weighted_row_extraction #(
  parameter int unsigned WEIGHT_FRAC_BITS = mwre_pkg::WEIGHT_FRAC_BITS_DEF,
  parameter int unsigned SAMPLE_BITS      = mwre_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // Configuration write channel
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [mwre_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [mwre_pkg::WORD_W-1:0]          cfg_data_i,
  // Pixel channel
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic signed [mwre_pkg::WORD_W-1:0]   pixel_value_i,
  input  logic [mwre_pkg::WORD_W-1:0]          pixel_variance_i,
  input  logic [mwre_pkg::WORD_W-1:0]          pixel_mask_i,
  input  logic signed [mwre_pkg::WEIGHT_W-1:0] profile_weight_i,
  input  logic [mwre_pkg::WORD_W-1:0]          trace_mask_i,
  input  logic                                 row_end_i,
  // Row result channel
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [mwre_pkg::FLUX_W-1:0]   row_flux_o,
  output logic [mwre_pkg::VAR_W-1:0]           row_variance_o,
  output logic signed [mwre_pkg::NORM_W-1:0]   row_norm_o,
  output logic [mwre_pkg::STATUS_W-1:0]        row_status_o
);

  localparam int unsigned ITEM_W = 2 * SAMPLE_BITS + mwre_pkg::WEIGHT_W + 2;

  logic                    push, pop;
  logic [ITEM_W-1:0]       push_item, pop_item;
  mwre_pkg::queue_status_t q_status;

  // Intake and classification.
  mwre_front #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .pixel_value_i    (pixel_value_i),
    .pixel_variance_i (pixel_variance_i),
    .pixel_mask_i     (pixel_mask_i),
    .profile_weight_i (profile_weight_i),
    .trace_mask_i     (trace_mask_i),
    .row_end_i        (row_end_i),
    .push_o           (push),
    .item_o           (push_item),
    .q_status_i       (q_status)
  );

  // Queue between the two ends.
  mwre_queue #(
    .WIDTH (ITEM_W),
    .DEPTH (mwre_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_item),
    .pop_i       (pop),
    .pop_data_o  (pop_item),
    .status_o    (q_status)
  );

  // Arithmetic and result delivery.
  mwre_back #(
    .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS),
    .SAMPLE_BITS      (SAMPLE_BITS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .pop_o          (pop),
    .item_i         (pop_item),
    .q_status_i     (q_status),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .row_flux_o     (row_flux_o),
    .row_variance_o (row_variance_o),
    .row_norm_o     (row_norm_o),
    .row_status_o   (row_status_o)
  );

endmodule

// ===== design/mwre_checker.sv =====
// ----------------------------------------------------------------------------
// mwre_checker: port-level checks of the row extraction block
// Watches the result channel and reset behaviour from the top-level ports.
// ----------------------------------------------------------------------------
module mwre_checker (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 out_valid_o,
  input logic                                 out_stall_i,
  input logic signed [mwre_pkg::FLUX_W-1:0]   row_flux_o,
  input logic [mwre_pkg::VAR_W-1:0]           row_variance_o,
  input logic signed [mwre_pkg::NORM_W-1:0]   row_norm_o,
  input logic [mwre_pkg::STATUS_W-1:0]        row_status_o
);

  // A stalled result word stays offered and unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(row_flux_o) &&
      $stable(row_variance_o) && $stable(row_norm_o) && $stable(row_status_o))
  else $error("stalled row result changed or was withdrawn");

  // A good row never has a zero weight sum.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (row_status_o == mwre_pkg::STATUS_OK) |-> (row_norm_o != '0))
  else $error("row reported good with a zero weight sum");

  // No result is offered as reset is released.
  assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_o)
  else $error("row result offered straight out of reset");

endmodule

bind masked_weighted_row_extraction mwre_checker u_mwre_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .row_flux_o     (row_flux_o),
  .row_variance_o (row_variance_o),
  .row_norm_o     (row_norm_o),
  .row_status_o   (row_status_o)
);
